// ===== design/assert_macros.svh =====
// assertion macros used by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, held off while reset is active
`define SBR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sbr assertion failed");

// clocked check that also holds during reset
`define SBR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sbr assertion failed");

`else

`define SBR_ASSERT(label, prop)
`define SBR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== design/sbr_pkg.sv =====
`default_nettype none

package sbr_pkg;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = $clog2(WORD_W);
    localparam int CFG_IDX_W = 2;
    localparam int SHIFT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RESEED = 2'd1;

    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd1;
    localparam logic [WORD_W-1:0] RESEED_RESET = 32'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_APPLY
    } t_state;

    typedef enum logic [1:0] {
        PH_MOD,
        PH_ROUND1,
        PH_ROUND2
    } t_phase;

endpackage

`default_nettype wire

// ===== design/seeded_bounded_random_unit.sv =====
// seeded bounded random unit
// input channel s_axis: one item carries the range bound n in tdata.
// output channel m_axis: tdata is the old seed mod n (the old seed itself
// when n is zero), tuser flags a zero bound.
// config port: i_cfg_we with i_cfg_idx 0 loads the seed word, index 1 loads
// the mix word; write only while the unit is idle.
// each item runs three passes through one shared restoring divider, one
// quotient bit per cycle: seed mod n, then the two mixing rounds.
// each pass runs setup, 32 divide steps and apply; the last apply of an
// item loads the result into the output register, which offers it on
// m_axis. that divider loop sets the rate.
// the unit takes one item at a time: s_axis_tready is high only when idle
// and the output register is empty.
// a stalled receiver holds the result in the output register, and no new
// item is taken until it has been delivered.
// reset (synchronous, active low) sets seed to 1 and mix to 0 and empties
// the output register.
`default_nettype none

module seeded_bounded_random_unit
    import sbr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] range_bound
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [WORD_W-1:0]         m_axis_tdata,   // [31:0] random_value
    output logic                      m_axis_tuser    // [0] zero_bound
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [WORD_W-1:0] r_seed, n_seed;
    logic [WORD_W-1:0] r_mix, n_mix;
    logic [WORD_W-1:0] r_bound, n_bound;
    logic [WORD_W-1:0] r_res, n_res;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [WORD_W-1:0] r_dvs, n_dvs;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic              r_out_zero, n_out_zero;

    logic              in_accept;
    logic              cnt_last;
    logic [WORD_W:0]   trial;
    logic              borrow;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] sum_sm;
    logic [WORD_W-1:0] mix_inc;
    logic [SHIFT_W-1:0] k;
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] mix_r2;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cnt_last      = (r_cnt == CNT_W'(WORD_W - 1));
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_zero;

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial  = {r_rem, r_dvd[WORD_W-1]} - {1'b0, r_dvs};
    assign borrow = trial[WORD_W];

    assign sum_sm   = r_seed + r_mix;
    assign mix_inc  = r_mix + WORD_W'(1);
    assign k        = r_dvd[SHIFT_W-1:0];
    assign low_mask = (WORD_W'(1) << k) - WORD_W'(1);
    assign mix_r2   = (r_mix << k) | low_mask;

    // candidate word of the current round
    always_comb begin
        cand = r_res;
        case (r_phase)
            PH_ROUND1: cand = (r_res != '0) ? r_res : sum_sm;
            PH_ROUND2: cand = (mix_inc != '0) ? mix_inc : sum_sm;
            default:   cand = r_res;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_accept) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV:   if (cnt_last) n_state = ST_APPLY;
            ST_APPLY: n_state = (r_phase == PH_ROUND2) ? ST_IDLE : ST_SETUP;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase     = r_phase;
        n_seed      = r_seed;
        n_mix       = r_mix;
        n_bound     = r_bound;
        n_res       = r_res;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_zero  = r_out_zero;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cfg_we && i_cfg_idx == REG_INITIAL_SEED) begin
                    n_seed = i_cfg_data;
                end
                if (i_cfg_we && i_cfg_idx == REG_INITIAL_RESEED) begin
                    n_mix = i_cfg_data;
                end
                if (in_accept) begin
                    n_bound = s_axis_tdata;
                    n_phase = PH_MOD;
                end
            end
            ST_SETUP: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_phase == PH_MOD) begin
                    n_dvd = r_seed;
                    n_dvs = r_bound;
                end else if (cand < r_seed) begin
                    n_dvd = r_seed;
                    n_dvs = cand;
                end else begin
                    n_dvd = cand;
                    n_dvs = r_seed;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                n_rem = borrow ? {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]} : trial[WORD_W-1:0];
                n_dvd = {r_dvd[WORD_W-2:0], ~borrow};
            end
            ST_APPLY: begin
                case (r_phase)
                    PH_MOD: begin
                        n_res   = (r_bound != '0) ? r_rem : r_seed;
                        n_phase = PH_ROUND1;
                    end
                    PH_ROUND1: begin
                        n_mix   = ((r_mix | r_seed) << k) ^ r_seed;
                        n_phase = PH_ROUND2;
                    end
                    PH_ROUND2: begin
                        n_mix       = mix_r2;
                        n_seed      = r_seed ^ mix_r2;
                        n_out_valid = 1'b1;
                        n_out_data  = r_res;
                        n_out_zero  = (r_bound == '0);
                    end
                    default: n_phase = PH_MOD;
                endcase
            end
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_MOD;
            r_seed      <= SEED_RESET;
            r_mix       <= RESEED_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_seed      <= n_seed;
            r_mix       <= n_mix;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound    <= n_bound;
        r_res      <= n_res;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
        r_out_zero <= n_out_zero;
    end

`include "assert_macros.svh"

    `SBR_ASSERT(a_accept_starts_mod, in_accept |=> (r_state == ST_SETUP && r_phase == PH_MOD))
    `SBR_ASSERT(a_div_ends_in_apply, (r_state == ST_DIV && cnt_last) |=> (r_state == ST_APPLY))
    `SBR_ASSERT(a_result_after_round2, $rose(r_out_valid) |-> $past(r_state == ST_APPLY && r_phase == PH_ROUND2))
    `SBR_ASSERT(a_busy_not_ready, (r_state != ST_IDLE) |-> !s_axis_tready)
    `SBR_ASSERT(a_no_item_while_held, (r_out_valid && !m_axis_tready) |=> (r_state != ST_SETUP))

endmodule

`default_nettype wire
